// File: rtl/lci_pkg.sv
// Shared types, constants and helper functions for the link-cell index unit.
// No dependencies; every other rtl file but lci_fifo refers to this package by scoped name.
package lci_pkg;

  // Field widths
  localparam int GW = 7;   // grid register width
  localparam int CW = 8;   // signed coordinate width
  localparam int IW = 19;  // linear index width
  localparam int PW = 13;  // width of grid products (gx*gy, (gx+2)*(gy+2), ...)

  // Largest grid size per axis; the widths above are sized for it
  localparam int MAX_GRID = 64;

  // Action codes
  localparam logic [1:0] ACT_T2I   = 2'd0;
  localparam logic [1:0] ACT_I2T   = 2'd1;
  localparam logic [1:0] ACT_NBR   = 2'd2;
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;

  // Operation after classification
  typedef enum logic [1:0] {
    OP_T2I,
    OP_I2T,
    OP_NBR,
    OP_ERR
  } op_t;

  // Part of the cell space: local block or one of the six halo planes
  typedef enum logic [2:0] {
    RG_LOCAL,
    RG_XLO,
    RG_XHI,
    RG_YLO,
    RG_YHI,
    RG_ZLO,
    RG_ZHI
  } region_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_T2I_A,
    ST_T2I_B,
    ST_PREP,
    ST_EMIT,
    ST_SINGLE
  } state_t;

  // Classified item travelling from front to back
  typedef struct packed {
    op_t                   op;
    region_t               rg;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
    logic [IW-1:0]         idx;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [IW-1:0]         index;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
    logic                  last;
    logic                  err;
  } result_t;

  // Grid geometry derived from the configuration registers
  typedef struct packed {
    logic [GW-1:0] gx;
    logic [GW-1:0] gy;
    logic [GW-1:0] gz;
    logic [GW-1:0] gxp2;
    logic [PW-1:0] gxy;
    logic [IW-1:0] nl;     // local cell count
    logic [IW-1:0] th1;    // start of +x plane
    logic [IW-1:0] th2;    // start of -y plane
    logic [IW-1:0] th3;    // start of +y plane
    logic [IW-1:0] th4;    // start of -z plane
    logic [IW-1:0] th5;    // start of +z plane
    logic [IW-1:0] total;  // total cell count
  } geom_t;

  // First linear index of a region
  function automatic logic [IW-1:0] region_base(input geom_t g, input region_t r);
    logic [IW-1:0] b;
    unique case (r)
      RG_LOCAL: b = '0;
      RG_XLO:   b = g.nl;
      RG_XHI:   b = g.th1;
      RG_YLO:   b = g.th2;
      RG_YHI:   b = g.th3;
      RG_ZLO:   b = g.th4;
      RG_ZHI:   b = g.th5;
      default:  b = '0;
    endcase
    return b;
  endfunction

  // Periodic neighbour coordinate: n = 0, 1, 2 stands for offset -1, 0, +1
  function automatic logic [GW-1:0] wrap_step(input logic [GW-1:0] c,
                                             input logic [GW-1:0] g,
                                             input logic [1:0] n);
    logic [GW-1:0] r;
    if (n == 2'd0) begin
      r = (c == '0) ? g - GW'(1) : c - GW'(1);
    end else if (n == 2'd1) begin
      r = c;
    end else begin
      r = (c == g - GW'(1)) ? '0 : c + GW'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/link_cell_index_unit.sv
// Link-cell index unit: tuple to index, index to tuple and 27-neighbour listing.
// Tuple to index passes ST_T2I_A, and ST_T2I_B as well for a local cell; index to tuple
// uses the serial divider, once for a halo index and twice for a local one.
// A neighbour item holds the back end for two divisions, six multiplier steps and
// 27 result beats, longer under result stalls. Up to 3 items wait in front.
// Reset (rst, synchronous): queues empty, grid registers 4; geometry then settles.
module link_cell_index_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    action,
  input  logic signed [lci_pkg::CW-1:0] coord_x,
  input  logic signed [lci_pkg::CW-1:0] coord_y,
  input  logic signed [lci_pkg::CW-1:0] coord_z,
  input  logic [lci_pkg::IW-1:0]        box_index,
  output logic                          empty,
  input  logic                          pop,
  output logic [lci_pkg::IW-1:0]        result_index,
  output logic signed [lci_pkg::CW-1:0] result_x,
  output logic signed [lci_pkg::CW-1:0] result_y,
  output logic signed [lci_pkg::CW-1:0] result_z,
  output logic                          last,
  output logic                          error,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [lci_pkg::GW-1:0]        cfg_data
);

  lci_pkg::geom_t   geom;
  lci_pkg::item_t   f_item, b_item;
  logic             f_push, iq_full, iq_empty, iq_pop;
  lci_pkg::result_t res_in, res_out;
  logic             res_push, rq_full;

  lci_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  lci_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .box_index (box_index),
    .geom      (geom),
    .q_push    (f_push),
    .q_item    (f_item),
    .q_full    (iq_full)
  );

  lci_fifo #(.WIDTH($bits(lci_pkg::item_t))) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .full  (iq_full),
    .pop   (iq_pop),
    .dout  (b_item),
    .empty (iq_empty)
  );

  lci_back u_back (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .q_empty  (iq_empty),
    .q_item   (b_item),
    .q_pop    (iq_pop),
    .res_push (res_push),
    .res      (res_in),
    .res_full (rq_full)
  );

  lci_fifo #(.WIDTH($bits(lci_pkg::result_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (rq_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign result_index = res_out.index;
  assign result_x     = res_out.x;
  assign result_y     = res_out.y;
  assign result_z     = res_out.z;
  assign last         = res_out.last;
  assign error        = res_out.err;

endmodule

// File: rtl/lci_fifo.sv
// Two-entry first-in first-out buffer for one packed word.
// Depends on nothing; used for the item queue and the result queue.
module lci_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/lci_cfg.sv
// Grid configuration registers and the geometry derived from them.
// Depends on lci_pkg; three register stages after a write the geometry is settled.
module lci_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [lci_pkg::GW-1:0]   cfg_data,
  output lci_pkg::geom_t           geom
);

  localparam int GW = lci_pkg::GW;
  localparam int PW = lci_pkg::PW;
  localparam int IW = lci_pkg::IW;
  localparam logic [GW-1:0] MAX_V = GW'(lci_pkg::MAX_GRID);

  logic [GW-1:0] gx, gy, gz;
  logic [GW-1:0] wval;

  // stage 1
  logic [GW-1:0] gxp2;
  logic [PW-1:0] gxy, gyz, gxp2gz, gxp2gyp2;
  // stage 2
  logic [IW-1:0] nl;
  // stage 3
  logic [IW-1:0] th1, th2, th3, th4, th5, total;

  logic [2*GW-1:0] p_xy, p_yz, p_xz, p_xy2;
  logic [GW-1:0]   ax2, ay2;
  logic [IW-1:0]   gyz_w, gxz_w, gxy2_w;

  // clamp written value to 2..MAX_GRID
  always_comb begin
    if (cfg_data < GW'(2)) begin
      wval = GW'(2);
    end else if (cfg_data > MAX_V) begin
      wval = MAX_V;
    end else begin
      wval = cfg_data;
    end
  end

  // grid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gx <= GW'(4);
      gy <= GW'(4);
      gz <= GW'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lci_pkg::REG_GRID_X: gx <= wval;
        lci_pkg::REG_GRID_Y: gy <= wval;
        lci_pkg::REG_GRID_Z: gz <= wval;
        default: ;
      endcase
    end
  end

  // stage 1: small products
  assign ax2   = gx + GW'(2);
  assign ay2   = gy + GW'(2);
  assign p_xy  = {{GW{1'b0}}, gx} * {{GW{1'b0}}, gy};
  assign p_yz  = {{GW{1'b0}}, gy} * {{GW{1'b0}}, gz};
  assign p_xz  = {{GW{1'b0}}, ax2} * {{GW{1'b0}}, gz};
  assign p_xy2 = {{GW{1'b0}}, ax2} * {{GW{1'b0}}, ay2};

  always_ff @(posedge clk) begin
    gxp2     <= ax2;
    gxy      <= p_xy[PW-1:0];
    gyz      <= p_yz[PW-1:0];
    gxp2gz   <= p_xz[PW-1:0];
    gxp2gyp2 <= p_xy2[PW-1:0];
  end

  // stage 2: local cell count
  always_ff @(posedge clk) begin
    nl <= {{(IW-PW){1'b0}}, gxy} * {{(IW-GW){1'b0}}, gz};
  end

  // stage 3: region boundaries
  assign gyz_w  = {{(IW-PW){1'b0}}, gyz};
  assign gxz_w  = {{(IW-PW){1'b0}}, gxp2gz};
  assign gxy2_w = {{(IW-PW){1'b0}}, gxp2gyp2};

  always_ff @(posedge clk) begin
    th1   <= nl + gyz_w;
    th2   <= nl + (gyz_w << 1);
    th3   <= nl + (gyz_w << 1) + gxz_w;
    th4   <= nl + (gyz_w << 1) + (gxz_w << 1);
    th5   <= nl + (gyz_w << 1) + (gxz_w << 1) + gxy2_w;
    total <= nl + (gyz_w << 1) + (gxz_w << 1) + (gxy2_w << 1);
  end

  always_comb begin
    geom.gx    = gx;
    geom.gy    = gy;
    geom.gz    = gz;
    geom.gxp2  = gxp2;
    geom.gxy   = gxy;
    geom.nl    = nl;
    geom.th1   = th1;
    geom.th2   = th2;
    geom.th3   = th3;
    geom.th4   = th4;
    geom.th5   = th5;
    geom.total = total;
  end

endmodule

// File: rtl/lci_front.sv
// Front end: takes input beats, range-checks coordinates and picks op and region.
// Depends on lci_pkg; hands classified items to the item queue.
module lci_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  logic signed [lci_pkg::CW-1:0] coord_x,
  input  logic signed [lci_pkg::CW-1:0] coord_y,
  input  logic signed [lci_pkg::CW-1:0] coord_z,
  input  logic [lci_pkg::IW-1:0]       box_index,
  input  lci_pkg::geom_t               geom,
  output logic                         q_push,
  output lci_pkg::item_t               q_item,
  input  logic                         q_full
);

  localparam int CW = lci_pkg::CW;

  logic             fv;
  lci_pkg::item_t   cls;
  logic             accept;
  logic             in_range;
  logic signed [CW-1:0] sgx, sgy, sgz;

  // -1..g, compared as signed values
  function automatic logic in_span(input logic signed [CW-1:0] c,
                                   input logic signed [CW-1:0] g);
    return (c >= $signed(-CW'(1))) && (c <= g);
  endfunction

  assign sgx = $signed({1'b0, geom.gx});
  assign sgy = $signed({1'b0, geom.gy});
  assign sgz = $signed({1'b0, geom.gz});

  assign full   = fv && q_full;
  assign accept = push && !full;
  assign q_push = fv && !q_full;

  // classify
  always_comb begin
    in_range = in_span(coord_x, sgx) && in_span(coord_y, sgy) && in_span(coord_z, sgz);
    cls.x    = coord_x;
    cls.y    = coord_y;
    cls.z    = coord_z;
    cls.idx  = box_index;
    unique case (action)
      lci_pkg::ACT_T2I: cls.op = in_range ? lci_pkg::OP_T2I : lci_pkg::OP_ERR;
      lci_pkg::ACT_I2T: cls.op = lci_pkg::OP_I2T;
      lci_pkg::ACT_NBR: cls.op = lci_pkg::OP_NBR;
      default:          cls.op = lci_pkg::OP_ERR;
    endcase
    // halo planes take precedence z, then y, then x
    priority if (coord_z == sgz) begin
      cls.rg = lci_pkg::RG_ZHI;
    end else if (coord_z == -CW'(1)) begin
      cls.rg = lci_pkg::RG_ZLO;
    end else if (coord_y == sgy) begin
      cls.rg = lci_pkg::RG_YHI;
    end else if (coord_y == -CW'(1)) begin
      cls.rg = lci_pkg::RG_YLO;
    end else if (coord_x == sgx) begin
      cls.rg = lci_pkg::RG_XHI;
    end else if (coord_x == -CW'(1)) begin
      cls.rg = lci_pkg::RG_XLO;
    end else begin
      cls.rg = lci_pkg::RG_LOCAL;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (accept) begin
      q_item <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

endmodule

// File: rtl/lci_back.sv
// Back end: sequencer with a shared multiplier and a serial divider that turns
// classified items into result beats. Depends on lci_pkg.
module lci_back (
  input  logic               clk,
  input  logic               rst,
  input  lci_pkg::geom_t     geom,
  input  logic               q_empty,
  input  lci_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               res_push,
  output lci_pkg::result_t   res,
  input  logic               res_full
);

  localparam int GW = lci_pkg::GW;
  localparam int CW = lci_pkg::CW;
  localparam int IW = lci_pkg::IW;
  localparam int PW = lci_pkg::PW;
  localparam int MW = PW + GW;
  localparam logic [4:0] DIV_LAST = 5'(IW - 1);

  lci_pkg::state_t  state, state_next;
  lci_pkg::item_t   it;
  lci_pkg::region_t rg, rg_c;

  logic [IW-1:0]         acc;
  logic signed [CW-1:0]  ox, oy, oz;
  logic                  oerr;
  logic [GW-1:0]         div_rem, div_d, rem_n;
  logic [IW-1:0]         div_q, q_fin;
  logic [4:0]            div_cnt;
  logic                  div_second;
  logic [GW:0]           trial;
  logic                  ge;
  logic                  div_done;
  logic                  chk_err;

  logic [2:0]            pc;
  logic [2:0]            pcm3;
  logic [1:0]            psel;
  logic [IW-1:0]         py [3];
  logic [IW-1:0]         pz [3];
  logic [1:0]            ni, nj, nk;
  logic                  nlast;
  logic [GW-1:0]         wx, wy_s, wz_s;
  logic [IW-1:0]         li;

  logic [PW-1:0]         mul_a;
  logic [GW-1:0]         mul_b;
  logic [MW-1:0]         mul_p;
  logic [GW-1:0]         m1, a1, add1;
  logic signed [CW-1:0]  xp1, yp1;

  // shared multiplier
  assign xp1 = it.x + CW'(1);
  assign yp1 = it.y + CW'(1);

  always_comb begin
    unique case (rg)
      lci_pkg::RG_LOCAL: begin m1 = geom.gx;   a1 = it.y[GW-1:0]; add1 = it.x[GW-1:0]; end
      lci_pkg::RG_XLO,
      lci_pkg::RG_XHI:   begin m1 = geom.gy;   a1 = it.z[GW-1:0]; add1 = it.y[GW-1:0]; end
      lci_pkg::RG_YLO,
      lci_pkg::RG_YHI:   begin m1 = geom.gxp2; a1 = it.z[GW-1:0]; add1 = xp1[GW-1:0]; end
      default:           begin m1 = geom.gxp2; a1 = yp1[GW-1:0];  add1 = xp1[GW-1:0]; end
    endcase
  end

  assign pcm3 = pc - 3'd3;
  assign psel = (pc < 3'd3) ? pc[1:0] : pcm3[1:0];
  assign wy_s = lci_pkg::wrap_step(oy[GW-1:0], geom.gy, psel);
  assign wz_s = lci_pkg::wrap_step(oz[GW-1:0], geom.gz, psel);

  always_comb begin
    unique case (state)
      lci_pkg::ST_T2I_A: begin mul_a = {{(PW-GW){1'b0}}, m1}; mul_b = a1; end
      lci_pkg::ST_T2I_B: begin mul_a = geom.gxy; mul_b = it.z[GW-1:0]; end
      lci_pkg::ST_PREP: begin
        if (pc < 3'd3) begin
          mul_a = {{(PW-GW){1'b0}}, geom.gx};
          mul_b = wy_s;
        end else begin
          mul_a = geom.gxy;
          mul_b = wz_s;
        end
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = {{GW{1'b0}}, mul_a} * {{PW{1'b0}}, mul_b};

  // serial divider, one quotient bit a cycle
  assign trial    = {div_rem, div_q[IW-1]};
  assign ge       = (trial >= {1'b0, div_d});
  assign rem_n    = ge ? GW'(trial - {1'b0, div_d}) : trial[GW-1:0];
  assign q_fin    = {div_q[IW-2:0], ge};
  assign div_done = (state == lci_pkg::ST_DIV) && (div_cnt == DIV_LAST);

  // region of a linear index
  always_comb begin
    priority if (it.idx < geom.nl) begin
      rg_c = lci_pkg::RG_LOCAL;
    end else if (it.idx < geom.th1) begin
      rg_c = lci_pkg::RG_XLO;
    end else if (it.idx < geom.th2) begin
      rg_c = lci_pkg::RG_XHI;
    end else if (it.idx < geom.th3) begin
      rg_c = lci_pkg::RG_YLO;
    end else if (it.idx < geom.th4) begin
      rg_c = lci_pkg::RG_YHI;
    end else if (it.idx < geom.th5) begin
      rg_c = lci_pkg::RG_ZLO;
    end else begin
      rg_c = lci_pkg::RG_ZHI;
    end
    chk_err = (it.op == lci_pkg::OP_I2T) ? (it.idx >= geom.total) : (it.idx >= geom.nl);
  end

  // neighbour index
  assign wx    = lci_pkg::wrap_step(ox[GW-1:0], geom.gx, ni);
  assign li    = {{(IW-GW){1'b0}}, wx} + py[nj] + pz[nk];
  assign nlast = (ni == 2'd2) && (nj == 2'd2) && (nk == 2'd2);

  // result beat
  always_comb begin
    res_push = ((state == lci_pkg::ST_SINGLE) || (state == lci_pkg::ST_EMIT)) && !res_full;
    if (state == lci_pkg::ST_EMIT) begin
      res.index = li;
      res.x     = '0;
      res.y     = '0;
      res.z     = '0;
      res.last  = nlast;
      res.err   = 1'b0;
    end else begin
      res.index = acc;
      res.x     = ox;
      res.y     = oy;
      res.z     = oz;
      res.last  = 1'b1;
      res.err   = oerr;
    end
  end

  assign q_pop = (state == lci_pkg::ST_IDLE) && !q_empty;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lci_pkg::ST_IDLE: begin
        if (q_pop) begin
          unique case (q_item.op)
            lci_pkg::OP_ERR: state_next = lci_pkg::ST_SINGLE;
            lci_pkg::OP_T2I: state_next = lci_pkg::ST_T2I_A;
            default:         state_next = lci_pkg::ST_CHECK;
          endcase
        end
      end
      lci_pkg::ST_CHECK: state_next = chk_err ? lci_pkg::ST_SINGLE : lci_pkg::ST_DIV;
      lci_pkg::ST_DIV: begin
        if (div_done && !(rg == lci_pkg::RG_LOCAL && !div_second)) begin
          state_next = (it.op == lci_pkg::OP_I2T) ? lci_pkg::ST_SINGLE : lci_pkg::ST_PREP;
        end
      end
      lci_pkg::ST_T2I_A:
        state_next = (rg == lci_pkg::RG_LOCAL) ? lci_pkg::ST_T2I_B : lci_pkg::ST_SINGLE;
      lci_pkg::ST_T2I_B: state_next = lci_pkg::ST_SINGLE;
      lci_pkg::ST_PREP:  if (pc == 3'd5) state_next = lci_pkg::ST_EMIT;
      lci_pkg::ST_EMIT:  if (res_push && nlast) state_next = lci_pkg::ST_IDLE;
      lci_pkg::ST_SINGLE: if (res_push) state_next = lci_pkg::ST_IDLE;
      default: state_next = lci_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      lci_pkg::ST_IDLE: begin
        if (q_pop) begin
          it   <= q_item;
          rg   <= q_item.rg;
          acc  <= '0;
          ox   <= '0;
          oy   <= '0;
          oz   <= '0;
          oerr <= (q_item.op == lci_pkg::OP_ERR);
        end
      end
      lci_pkg::ST_CHECK: begin
        if (chk_err) begin
          oerr <= 1'b1;
        end else begin
          rg         <= rg_c;
          div_q      <= it.idx - lci_pkg::region_base(geom, rg_c);
          div_rem    <= '0;
          div_cnt    <= '0;
          div_second <= 1'b0;
          unique case (rg_c)
            lci_pkg::RG_LOCAL:               div_d <= geom.gx;
            lci_pkg::RG_XLO, lci_pkg::RG_XHI: div_d <= geom.gy;
            default:                         div_d <= geom.gxp2;
          endcase
        end
      end
      lci_pkg::ST_DIV: begin
        div_q   <= q_fin;
        div_rem <= rem_n;
        div_cnt <= div_cnt + 5'd1;
        pc      <= '0;
        if (div_done) begin
          unique case (rg)
            lci_pkg::RG_LOCAL: begin
              if (!div_second) begin
                ox         <= $signed({1'b0, rem_n});
                div_rem    <= '0;
                div_d      <= geom.gy;
                div_cnt    <= '0;
                div_second <= 1'b1;
              end else begin
                oy <= $signed({1'b0, rem_n});
                oz <= $signed(q_fin[CW-1:0]);
              end
            end
            lci_pkg::RG_XLO, lci_pkg::RG_XHI: begin
              ox <= (rg == lci_pkg::RG_XLO) ? -CW'(1) : $signed({1'b0, geom.gx});
              oy <= $signed({1'b0, rem_n});
              oz <= $signed(q_fin[CW-1:0]);
            end
            lci_pkg::RG_YLO, lci_pkg::RG_YHI: begin
              oy <= (rg == lci_pkg::RG_YLO) ? -CW'(1) : $signed({1'b0, geom.gy});
              ox <= $signed({1'b0, rem_n}) - CW'(1);
              oz <= $signed(q_fin[CW-1:0]);
            end
            default: begin
              oz <= (rg == lci_pkg::RG_ZLO) ? -CW'(1) : $signed({1'b0, geom.gz});
              ox <= $signed({1'b0, rem_n}) - CW'(1);
              oy <= $signed(q_fin[CW-1:0]) - CW'(1);
            end
          endcase
        end
      end
      lci_pkg::ST_T2I_A: acc <= lci_pkg::region_base(geom, rg)
                                + {{(IW-GW){1'b0}}, add1} + mul_p[IW-1:0];
      lci_pkg::ST_T2I_B: acc <= acc + mul_p[IW-1:0];
      lci_pkg::ST_PREP: begin
        if (pc < 3'd3) begin
          py[psel] <= mul_p[IW-1:0];
        end else begin
          pz[psel] <= mul_p[IW-1:0];
        end
        pc <= pc + 3'd1;
        ni <= '0;
        nj <= '0;
        nk <= '0;
      end
      lci_pkg::ST_EMIT: begin
        if (res_push) begin
          if (nk == 2'd2) begin
            nk <= '0;
            if (nj == 2'd2) begin
              nj <= '0;
              ni <= ni + 2'd1;
            end else begin
              nj <= nj + 2'd1;
            end
          end else begin
            nk <= nk + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // never write into a full result queue
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result beat pushed into full queue");

  // the final neighbour beat ends the item
  assert property (@(posedge clk) disable iff (rst)
    (state == lci_pkg::ST_EMIT && res_push && nlast) |=> state == lci_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after last neighbour");

  // an error beat is always the only one of its item
  assert property (@(posedge clk) disable iff (rst) (res_push && res.err) |-> res.last)
    else $error("error beat without last");

  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == lci_pkg::ST_DIV && div_cnt != 5'd0) |-> (div_rem < div_d))
    else $error("divider remainder out of range");
`endif

endmodule
